FILE: hdl/kcl_pkg.sv
// Shared types, constants and the keypad decode function for the keypad code lock.
package kcl_pkg;

    // Default for the longest entry that is tracked before it is forced wrong.
    localparam int MAX_DIGITS_DEF = 8;

    // Configuration register indexes.
    localparam int          CFG_IDX_W        = 8;
    localparam logic [7:0]  CFG_CODE_LENGTH  = 8'd0;
    localparam logic [7:0]  CFG_CODE_DIGITS  = 8'd1;
    localparam logic [7:0]  CFG_TICKS_PER_S  = 8'd2;
    localparam logic [7:0]  CFG_OPEN_SECONDS = 8'd3;

    // Configuration reset values.
    localparam logic [3:0]  RST_CODE_LENGTH  = 4'd4;
    localparam logic [31:0] RST_CODE_DIGITS  = 32'h0000_4321;
    localparam logic [15:0] RST_TICKS_PER_S  = 16'd500;
    localparam logic [7:0]  RST_OPEN_SECONDS = 8'd4;

    // Input command codes.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_KEY  = 1'b1;

    // Result event codes.
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_TAKEN   = 3'd1;
    localparam logic [2:0] EV_CORRECT = 3'd2;
    localparam logic [2:0] EV_WRONG   = 3'd3;
    localparam logic [2:0] EV_CLEARED = 3'd4;

    // Decoded key kinds.
    localparam logic [1:0] KIND_DIGIT = 2'd0;
    localparam logic [1:0] KIND_STAR  = 2'd1;
    localparam logic [1:0] KIND_HASH  = 2'd2;
    localparam logic [1:0] KIND_BAD   = 2'd3;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [3:0]  code_length;
        logic [31:0] code_digits;
        logic [15:0] ticks_per_second;
        logic [7:0]  open_seconds;
    } cfg_t;

    // One result word before packing onto the output bus.
    typedef struct packed {
        logic       motor_on;
        logic [2:0] event_res;
        logic [3:0] digits_entered;
        logic [7:0] seconds_open;
    } result_t;

    // Decoded key: kind plus digit value.
    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] digit;
    } key_t;

    // Map a raw row-major keypad code to a key kind and digit.
    function automatic key_t key_decode(input logic [4:0] code);
        key_t k;
        k.kind  = KIND_DIGIT;
        k.digit = 4'd0;
        unique case (code)
            5'd1:    k.digit = 4'd1;
            5'd2:    k.digit = 4'd2;
            5'd3:    k.digit = 4'd3;
            5'd5:    k.digit = 4'd4;
            5'd6:    k.digit = 4'd5;
            5'd7:    k.digit = 4'd6;
            5'd9:    k.digit = 4'd7;
            5'd10:   k.digit = 4'd8;
            5'd11:   k.digit = 4'd9;
            5'd14:   k.digit = 4'd0;
            5'd13:   k.kind  = KIND_STAR;
            5'd15:   k.kind  = KIND_HASH;
            default: k.kind  = KIND_BAD;
        endcase
        return k;
    endfunction

endpackage

FILE: hdl/kcl_cfg.sv
// Configuration register bank for the keypad code lock.
module kcl_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [kcl_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [31:0]                   wr_data,
    output kcl_pkg::cfg_t                 cfg
);
    import kcl_pkg::*;

    cfg_t cfg_reg;

    // Register writes; an index beyond the list leaves everything unchanged.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.code_length      <= RST_CODE_LENGTH;
            cfg_reg.code_digits      <= RST_CODE_DIGITS;
            cfg_reg.ticks_per_second <= RST_TICKS_PER_S;
            cfg_reg.open_seconds     <= RST_OPEN_SECONDS;
        end else if (wr_en) begin
            unique case (wr_index)
                CFG_CODE_LENGTH:  cfg_reg.code_length      <= wr_data[3:0];
                CFG_CODE_DIGITS:  cfg_reg.code_digits      <= wr_data;
                CFG_TICKS_PER_S:  cfg_reg.ticks_per_second <= wr_data[15:0];
                CFG_OPEN_SECONDS: cfg_reg.open_seconds     <= wr_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/kcl_core.sv
// Lock state and the combinational update of that state for one word.
module kcl_core #(
    parameter int MAX_DIGITS = kcl_pkg::MAX_DIGITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic             command,
    input  logic [4:0]       key_code,
    input  kcl_pkg::cfg_t    cfg,
    output kcl_pkg::result_t result
);
    import kcl_pkg::*;

    // The entry count saturates at MAX_DIGITS + 1.
    localparam int CW   = $clog2(MAX_DIGITS + 2);
    localparam int CMPW = (CW > 4) ? CW : 4;
    localparam logic [CW-1:0]   CNT_SAT = CW'(MAX_DIGITS + 1);
    localparam logic [CW-1:0]   CNT_MAX = CW'(MAX_DIGITS);
    localparam logic [CMPW-1:0] POS_LIM = CMPW'(8);

    logic [CW-1:0] entry_count_reg, entry_count_next;
    logic          mismatch_reg,    mismatch_next;
    logic          running_reg,     running_next;
    logic [15:0]   tick_count_reg,  tick_count_next;
    logic [7:0]    second_reg,      second_next;
    logic [2:0]    event_w;

    key_t            key;
    logic [15:0]     tick_inc;
    logic [7:0]      second_inc;
    logic [CMPW-1:0] pos_w;
    logic [CMPW-1:0] len_w;
    logic [3:0]      stored;
    logic            digit_ok;
    logic [CW-1:0]   count_inc;

    assign key        = key_decode(key_code);
    assign tick_inc   = tick_count_reg + 16'd1;
    assign second_inc = second_reg + 8'd1;
    assign pos_w      = CMPW'(entry_count_reg);
    assign len_w      = CMPW'(cfg.code_length);
    assign stored     = cfg.code_digits[{pos_w[2:0], 2'b00} +: 4];
    assign digit_ok   = (key.kind == KIND_DIGIT) && (pos_w < len_w) && (pos_w < POS_LIM)
                        && (entry_count_reg < CNT_MAX) && (stored == key.digit);
    assign count_inc  = (entry_count_reg < CNT_SAT) ? entry_count_reg + CW'(1)
                                                    : entry_count_reg;

    // Next state and event for the word at the input register.
    always_comb begin
        entry_count_next = entry_count_reg;
        mismatch_next    = mismatch_reg;
        running_next     = running_reg;
        tick_count_next  = tick_count_reg;
        second_next      = second_reg;
        event_w          = EV_NONE;
        if (command == CMD_TICK) begin
            tick_count_next = tick_inc;
            if (tick_inc >= cfg.ticks_per_second) begin
                tick_count_next = 16'd0;
                second_next     = second_inc;
                if (running_reg && (second_inc == cfg.open_seconds)) begin
                    running_next     = 1'b0;
                    entry_count_next = '0;
                    mismatch_next    = 1'b0;
                    event_w          = EV_CLEARED;
                end
            end
        end else if (!running_reg) begin
            unique case (key.kind)
                KIND_STAR: begin
                    entry_count_next = '0;
                    mismatch_next    = 1'b0;
                    event_w          = EV_CLEARED;
                end
                KIND_HASH: begin
                    if (!mismatch_reg && (pos_w == len_w)) begin
                        running_next    = 1'b1;
                        second_next     = 8'd0;
                        tick_count_next = 16'd0;
                        event_w         = EV_CORRECT;
                    end else begin
                        entry_count_next = '0;
                        mismatch_next    = 1'b0;
                        event_w          = EV_WRONG;
                    end
                end
                default: begin
                    entry_count_next = count_inc;
                    mismatch_next    = mismatch_reg || !digit_ok || (count_inc > CNT_MAX);
                    event_w          = EV_TAKEN;
                end
            endcase
        end
    end

    // State registers move only when the word goes to the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            mismatch_reg    <= 1'b0;
            running_reg     <= 1'b0;
            tick_count_reg  <= 16'd0;
            second_reg      <= 8'd0;
        end else if (advance) begin
            entry_count_reg <= entry_count_next;
            mismatch_reg    <= mismatch_next;
            running_reg     <= running_next;
            tick_count_reg  <= tick_count_next;
            second_reg      <= second_next;
        end
    end

    // Result as seen after this word.
    always_comb begin
        result.motor_on       = running_next;
        result.event_res      = event_w;
        result.digits_entered = 4'(entry_count_next);
        result.seconds_open   = running_next ? second_next : 8'd0;
    end

endmodule

FILE: hdl/keypad_code_lock.sv
// Top level of the keypad code lock: input register, core and output register.
//
//  Channel | Ports                          | Content
//  --------+--------------------------------+------------------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser | key_code in tdata, command in tuser
//  result  | m_tvalid m_tready m_tdata      | motor_on, event_res, digits_entered, seconds
//  config  | cfg_valid cfg_ready cfg_index cfg_data | register index and write data
//
// One word per cycle while the output register is not stalled: a word is taken
// into the input register, and when it moves on the core updates its state and
// loads the result into the output register.
// aresetn is synchronous and active low; it clears the lock state, the valid
// flags and restores the configuration defaults.
// A stalled result register holds its word; the input register keeps accepting
// as long as its word can move on in the same cycle.
module keypad_code_lock #(
    parameter int MAX_DIGITS = kcl_pkg::MAX_DIGITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [4:0] key_code, [7:5] zero
    input  logic                          s_tuser,   // [0] command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // [0] motor_on, [3:1] event_res,
                                                     // [7:4] digits_entered, [15:8] seconds_open
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import kcl_pkg::*;

    cfg_t    cfg;
    result_t result;

    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [4:0] in_key_reg;
    logic       out_valid_reg;
    result_t    out_word_reg;
    logic       advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    kcl_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    kcl_core #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .command  (in_cmd_reg),
        .key_code (in_key_reg),
        .cfg      (cfg),
        .result   (result)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg <= s_tuser;
            in_key_reg <= s_tdata[4:0];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_word_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_word_reg.seconds_open, out_word_reg.digits_entered,
                       out_word_reg.event_res, out_word_reg.motor_on};

endmodule

FILE: hdl/kcl_checker.sv
// Port-level assertions for the keypad code lock, bound to the top level.
module kcl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import kcl_pkg::*;

    // A stalled result word holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // With the motor off the seconds field reads zero.
    a_off_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[15:8] == 8'd0)
        else $error("seconds shown while motor is off");

    // A correct code turns the motor on with the seconds count at zero.
    a_correct: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:1] == EV_CORRECT |-> m_tdata[0] && m_tdata[15:8] == 8'd0)
        else $error("correct event without motor start");

    // Wrong and cleared events leave an empty entry and the motor off.
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3:1] == EV_WRONG || m_tdata[3:1] == EV_CLEARED)
        |-> !m_tdata[0] && m_tdata[7:4] == 4'd0)
        else $error("entry not cleared on wrong or cleared event");

    // A key is taken only while the motor is off.
    a_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:1] == EV_TAKEN |-> !m_tdata[0])
        else $error("key taken while motor runs");

endmodule

bind keypad_code_lock kcl_checker u_kcl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
